### hdl/vrcs_pkg.sv
// Package for the video receiver channel scan core.
// Holds the command codes, the transaction structs, the band/channel frequency
// table and the strength conversion. No dependencies.
package vrcs_pkg;

    // Command codes carried by each input transaction
    typedef enum logic [1:0] {
        CMD_SELECT = 2'd0,
        CMD_SCAN   = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    localparam logic [15:0]        MIN_DWELL_MS     = 16'd20;
    localparam logic [25:0]        US_PER_MS        = 26'd1000;
    localparam logic [31:0]        FRESH_TIMEOUT_US = 32'd1000000;
    localparam logic signed [15:0] LEVEL_FLOOR      = 16'sh8000;
    localparam logic [6:0]         PCT_FULL         = 7'd100;
    // (rssi + 100) at or above this gives full strength
    localparam logic signed [16:0] PCT_FULL_OFFSET  = 17'sd80;
    localparam logic signed [16:0] RSSI_OFFSET      = 17'sd100;

    // Scan band counter must hold the band count itself (up to 8)
    localparam int SCAN_BAND_W = 4;

    // Input transaction
    typedef struct packed {
        cmd_t               cmd;
        logic [2:0]         band;
        logic [2:0]         channel;
        logic [47:0]        now_us;
        logic               tune_ok;
        logic               has_sample;
        logic signed [15:0] rssi;
        logic               video_present;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic               ok;
        logic               tune_request;
        logic [12:0]        tune_mhz;
        logic               available;
        logic               scanning;
        logic               sample_fresh;
        logic               video_ok;
        logic [2:0]         cur_band;
        logic [2:0]         cur_channel;
        logic [12:0]        cur_mhz;
        logic signed [15:0] last_rssi;
        logic [6:0]         strength_pct;
    } result_t;

    // Band by channel frequency table in MHz; unused bands read as zero
    localparam logic [12:0] FREQ_ROM [0:7][0:7] = '{
        '{13'd5865, 13'd5845, 13'd5825, 13'd5805, 13'd5785, 13'd5765, 13'd5745, 13'd5725},
        '{13'd5733, 13'd5752, 13'd5771, 13'd5790, 13'd5809, 13'd5828, 13'd5847, 13'd5866},
        '{13'd5705, 13'd5685, 13'd5665, 13'd5645, 13'd5885, 13'd5905, 13'd5925, 13'd5945},
        '{13'd5740, 13'd5760, 13'd5780, 13'd5800, 13'd5820, 13'd5840, 13'd5860, 13'd5880},
        '{13'd5658, 13'd5695, 13'd5732, 13'd5769, 13'd5806, 13'd5843, 13'd5880, 13'd5917},
        '{13'd5362, 13'd5399, 13'd5436, 13'd5473, 13'd5510, 13'd5547, 13'd5584, 13'd5621},
        '{13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
        '{13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0}
    };

    function automatic logic [12:0] rom_mhz(input logic [2:0] b, input logic [2:0] c);
        return FREQ_ROM[b][c];
    endfunction

    // Strength 0..100: (rssi+100)*100/80, clamped. Between the clamps the
    // offset value is 1..79, so the scaling is x*5/4.
    function automatic logic [6:0] strength_of(input logic signed [15:0] r);
        logic signed [16:0] x;
        logic [8:0]         t;
        x = {r[15], r} + RSSI_OFFSET;
        t = 9'(x[6:0]) * 9'd5;
        if (x <= 17'sd0)
            return 7'd0;
        else if (x >= PCT_FULL_OFFSET)
            return PCT_FULL;
        else
            return 7'(t >> 2);
    endfunction

endpackage

### hdl/video_receiver_channel_scan_core.sv
// Channel scan controller for a 5.8 GHz video receiver.
//
// Input channel (in_valid / in_stall): one command transaction per cycle at
// most: select, begin scan, cancel scan, or a time tick with an optional
// receiver sample. The tuner's answer arrives as tune_ok with the same item.
// Output channel (out_valid / out_stall): exactly one result transaction per
// input transaction, in order: status flags, tuned point, last sample and any
// tune request issued by that command.
// Configuration channel (cfg_valid / cfg_ready): sets the scan dwell in ms;
// cfg_ready is always high; write only while no transaction is in flight.
// An accepted transaction is held in the input register, passes the update logic
// and is held in the result register, where out_valid rises. Throughput is one
// transaction per cycle while the receiver does not stall; the whole update for
// one command is combinational between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; in_stall rises only when both are full.
// Reset clears all status, the tuned point, the sample and the scan state,
// and sets the dwell to 20 ms.
// Depends on vrcs_pkg, vrcs_in_stage, vrcs_ctrl and vrcs_out_stage.
module video_receiver_channel_scan_core
    import vrcs_pkg::*;
#(
    parameter int BAND_COUNT        = 6,
    parameter int CHANNELS_PER_BAND = 8,
    parameter int TIME_BITS         = 48
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    // Input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [2:0]         band,
    input  logic [2:0]         channel,
    input  logic [47:0]        now_us,
    input  logic               tune_ok,
    input  logic               has_sample,
    input  logic signed [15:0] rssi,
    input  logic               video_present,
    // Output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic               tune_request,
    output logic [12:0]        tune_mhz,
    output logic               available,
    output logic               scanning,
    output logic               sample_fresh,
    output logic               video_ok,
    output logic [2:0]         cur_band,
    output logic [2:0]         cur_channel,
    output logic [12:0]        cur_mhz,
    output logic signed [15:0] last_rssi,
    output logic [6:0]         strength_pct
);

    item_t   in_item;
    item_t   item;
    result_t res;
    result_t res_out;
    logic    fire;
    logic    down_ready;

    assign cfg_ready = 1'b1;

    // Gather the input fields into one transaction
    always_comb
    begin
        in_item.cmd           = cmd_t'(cmd);
        in_item.band          = band;
        in_item.channel       = channel;
        in_item.now_us        = now_us;
        in_item.tune_ok       = tune_ok;
        in_item.has_sample    = has_sample;
        in_item.rssi          = rssi;
        in_item.video_present = video_present;
    end

    vrcs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .down_ready (down_ready),
        .fire       (fire),
        .item       (item)
    );

    vrcs_ctrl #(
        .BAND_COUNT        (BAND_COUNT),
        .CHANNELS_PER_BAND (CHANNELS_PER_BAND),
        .TIME_BITS         (TIME_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .res       (res)
    );

    vrcs_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .res_in     (res),
        .down_ready (down_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .res_out    (res_out)
    );

    // Spread the result transaction onto the output ports
    assign ok           = res_out.ok;
    assign tune_request = res_out.tune_request;
    assign tune_mhz     = res_out.tune_mhz;
    assign available    = res_out.available;
    assign scanning     = res_out.scanning;
    assign sample_fresh = res_out.sample_fresh;
    assign video_ok     = res_out.video_ok;
    assign cur_band     = res_out.cur_band;
    assign cur_channel  = res_out.cur_channel;
    assign cur_mhz      = res_out.cur_mhz;
    assign last_rssi    = res_out.last_rssi;
    assign strength_pct = res_out.strength_pct;

endmodule

### hdl/vrcs_in_stage.sv
// Input register of the channel scan core.
// Holds one accepted transaction until the update logic takes it; uses vrcs_pkg.
module vrcs_in_stage
    import vrcs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    input  logic  down_ready,
    output logic  fire,
    output item_t item
);

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;
    logic  load;

    // Hand the held transaction on whenever the result side has room
    assign fire     = vld_reg && down_ready;
    assign in_stall = vld_reg && !down_ready;
    assign load     = in_valid && !in_stall;
    assign item     = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
            vld_next = 1'b1;
        else if (fire)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

endmodule

### hdl/vrcs_ctrl.sv
// Update logic and state of the channel scan core: select, scan stepping,
// sample capture and freshness timeout. Uses vrcs_pkg.
module vrcs_ctrl
    import vrcs_pkg::*;
#(
    parameter int BAND_COUNT        = 6,
    parameter int CHANNELS_PER_BAND = 8,
    parameter int TIME_BITS         = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [15:0] cfg_data,
    input  logic        fire,
    input  item_t       item,
    output result_t     res
);

    // Configuration
    logic [15:0] dwell_reg;

    // Scan position and best candidate
    logic [SCAN_BAND_W-1:0] scan_band_reg, scan_band_next;
    logic [2:0]             scan_chan_reg, scan_chan_next;
    logic [2:0]             best_band_reg, best_band_next;
    logic [2:0]             best_chan_reg, best_chan_next;
    logic signed [15:0]     best_level_reg, best_level_next;

    // Times
    logic [TIME_BITS-1:0] next_step_reg, next_step_next;
    logic [TIME_BITS-1:0] last_sample_reg, last_sample_next;
    logic                 seen_reg, seen_next;

    // Status flags
    logic avail_reg, avail_next;
    logic scanning_reg, scanning_next;
    logic fresh_reg, fresh_next;
    logic video_reg, video_next;

    // Tuned point and last sample
    logic [2:0]         tuned_band_reg, tuned_band_next;
    logic [2:0]         tuned_chan_reg, tuned_chan_next;
    logic [12:0]        tuned_mhz_reg, tuned_mhz_next;
    logic signed [15:0] rssi_reg, rssi_next;
    logic [6:0]         pct_reg, pct_next;

    // Derived per-transaction values
    logic [TIME_BITS-1:0]   now_t;
    logic [15:0]            dwell_eff;
    logic [25:0]            dwell_us;
    logic [TIME_BITS-1:0]   deadline;
    logic                   timed_out;
    logic [SCAN_BAND_W-1:0] inc_band;
    logic [2:0]             inc_chan;

    // Working values of the update
    logic        do_sel;
    logic        do_cand;
    logic [2:0]  tgt_band;
    logic [2:0]  tgt_chan;
    logic        tgt_in_range;
    logic [12:0] mhz;
    logic        sel_ok;
    logic        ok_v;
    logic        treq;
    logic [12:0] tmhz;

    assign now_t     = TIME_BITS'(item.now_us);
    assign dwell_eff = (dwell_reg < MIN_DWELL_MS) ? MIN_DWELL_MS : dwell_reg;
    assign dwell_us  = 26'(dwell_eff) * US_PER_MS;
    assign deadline  = now_t + TIME_BITS'(dwell_us);
    assign timed_out = !seen_reg ||
                       ((now_t - last_sample_reg) > TIME_BITS'(FRESH_TIMEOUT_US));

    // Next scan position, band-major
    always_comb
    begin
        if (scan_chan_reg == 3'(CHANNELS_PER_BAND - 1))
        begin
            inc_chan = 3'd0;
            inc_band = scan_band_reg + 1'b1;
        end
        else
        begin
            inc_chan = scan_chan_reg + 1'b1;
            inc_band = scan_band_reg;
        end
    end

    // Command decode and state update
    always_comb
    begin
        scan_band_next   = scan_band_reg;
        scan_chan_next   = scan_chan_reg;
        best_band_next   = best_band_reg;
        best_chan_next   = best_chan_reg;
        best_level_next  = best_level_reg;
        next_step_next   = next_step_reg;
        last_sample_next = last_sample_reg;
        seen_next        = seen_reg;
        avail_next       = avail_reg;
        scanning_next    = scanning_reg;
        fresh_next       = fresh_reg;
        video_next       = video_reg;
        tuned_band_next  = tuned_band_reg;
        tuned_chan_next  = tuned_chan_reg;
        tuned_mhz_next   = tuned_mhz_reg;
        rssi_next        = rssi_reg;
        pct_next         = pct_reg;
        do_sel           = 1'b0;
        do_cand          = 1'b0;
        tgt_band         = item.band;
        tgt_chan         = item.channel;
        sel_ok           = 1'b0;
        ok_v             = 1'b1;
        treq             = 1'b0;
        tmhz             = 13'd0;

        case (item.cmd)
            CMD_SELECT:
            begin
                do_sel = 1'b1;
            end
            CMD_SCAN:
            begin
                scan_band_next  = '0;
                scan_chan_next  = 3'd0;
                best_band_next  = 3'd0;
                best_chan_next  = 3'd0;
                best_level_next = LEVEL_FLOOR;
                scanning_next   = 1'b1;
                next_step_next  = now_t;
                tgt_band        = 3'd0;
                tgt_chan        = 3'd0;
                do_cand         = 1'b1;
            end
            CMD_CANCEL:
            begin
                scanning_next = 1'b0;
            end
            CMD_TICK:
            begin
                if (avail_reg)
                begin
                    // Sample capture, or freshness timeout
                    if (item.has_sample)
                    begin
                        rssi_next        = item.rssi;
                        pct_next         = strength_of(item.rssi);
                        video_next       = item.video_present;
                        fresh_next       = 1'b1;
                        last_sample_next = now_t;
                        seen_next        = 1'b1;
                        if (scanning_reg && (item.rssi > best_level_reg))
                        begin
                            best_level_next = item.rssi;
                            best_band_next  = scan_band_reg[2:0];
                            best_chan_next  = scan_chan_reg;
                        end
                    end
                    else if (timed_out)
                    begin
                        fresh_next = 1'b0;
                        video_next = 1'b0;
                    end
                    // Dwell expired: step to the next channel or finish
                    if (scanning_reg && (now_t >= next_step_reg))
                    begin
                        scan_band_next = inc_band;
                        scan_chan_next = inc_chan;
                        if (inc_band >= SCAN_BAND_W'(BAND_COUNT))
                        begin
                            scanning_next = 1'b0;
                            tgt_band      = best_band_next;
                            tgt_chan      = best_chan_next;
                            do_sel        = 1'b1;
                        end
                        else
                        begin
                            tgt_band = inc_band[2:0];
                            tgt_chan = inc_chan;
                            do_cand  = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                scanning_next = scanning_reg;
            end
        endcase

        // Frequency lookup for whichever point is being tuned
        tgt_in_range = ({1'b0, tgt_band} < 4'(BAND_COUNT)) &&
                       ({1'b0, tgt_chan} < 4'(CHANNELS_PER_BAND));
        mhz = tgt_in_range ? rom_mhz(tgt_band, tgt_chan) : 13'd0;

        // Ordinary select; a zero table entry issues no tune
        if (do_sel)
        begin
            if (mhz == 13'd0)
            begin
                avail_next = 1'b0;
            end
            else
            begin
                treq = 1'b1;
                tmhz = mhz;
                if (!item.tune_ok)
                begin
                    avail_next = 1'b0;
                end
                else
                begin
                    sel_ok           = 1'b1;
                    tuned_band_next  = tgt_band;
                    tuned_chan_next  = tgt_chan;
                    tuned_mhz_next   = mhz;
                    avail_next       = 1'b1;
                    scanning_next    = 1'b0;
                    fresh_next       = 1'b0;
                    last_sample_next = now_t;
                    seen_next        = 1'b1;
                end
            end
        end

        // Scan candidate; a refusal abandons the scan
        if (do_cand)
        begin
            treq = 1'b1;
            tmhz = mhz;
            if (!item.tune_ok)
            begin
                avail_next    = 1'b0;
                scanning_next = 1'b0;
            end
            else
            begin
                sel_ok          = 1'b1;
                tuned_band_next = tgt_band;
                tuned_chan_next = tgt_chan;
                tuned_mhz_next  = mhz;
                avail_next      = 1'b1;
                fresh_next      = 1'b0;
                next_step_next  = deadline;
            end
        end

        if ((item.cmd == CMD_SELECT) || (item.cmd == CMD_SCAN))
            ok_v = sel_ok;
    end

    // Result of the transaction in flight
    always_comb
    begin
        res.ok           = ok_v;
        res.tune_request = treq;
        res.tune_mhz     = tmhz;
        res.available    = avail_next;
        res.scanning     = scanning_next;
        res.sample_fresh = fresh_next;
        res.video_ok     = video_next;
        res.cur_band     = tuned_band_next;
        res.cur_channel  = tuned_chan_next;
        res.cur_mhz      = tuned_mhz_next;
        res.last_rssi    = rssi_next;
        res.strength_pct = pct_next;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dwell_reg <= MIN_DWELL_MS;
        else if (cfg_valid)
            dwell_reg <= cfg_data;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_band_reg   <= '0;
            scan_chan_reg   <= 3'd0;
            best_band_reg   <= 3'd0;
            best_chan_reg   <= 3'd0;
            best_level_reg  <= LEVEL_FLOOR;
            next_step_reg   <= '0;
            last_sample_reg <= '0;
            seen_reg        <= 1'b0;
            avail_reg       <= 1'b0;
            scanning_reg    <= 1'b0;
            fresh_reg       <= 1'b0;
            video_reg       <= 1'b0;
            tuned_band_reg  <= 3'd0;
            tuned_chan_reg  <= 3'd0;
            tuned_mhz_reg   <= 13'd0;
            rssi_reg        <= 16'sd0;
            pct_reg         <= 7'd0;
        end
        else if (fire)
        begin
            scan_band_reg   <= scan_band_next;
            scan_chan_reg   <= scan_chan_next;
            best_band_reg   <= best_band_next;
            best_chan_reg   <= best_chan_next;
            best_level_reg  <= best_level_next;
            next_step_reg   <= next_step_next;
            last_sample_reg <= last_sample_next;
            seen_reg        <= seen_next;
            avail_reg       <= avail_next;
            scanning_reg    <= scanning_next;
            fresh_reg       <= fresh_next;
            video_reg       <= video_next;
            tuned_band_reg  <= tuned_band_next;
            tuned_chan_reg  <= tuned_chan_next;
            tuned_mhz_reg   <= tuned_mhz_next;
            rssi_reg        <= rssi_next;
            pct_reg         <= pct_next;
        end
    end

    // A live scan always points inside the table
    a_scan_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (scanning_reg && avail_reg) |-> (scan_band_reg < SCAN_BAND_W'(BAND_COUNT)))
        else $error("scan position beyond last band while scanning");

    // A failed select or scan start leaves the receiver unavailable
    a_fail_unavailable: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !res.ok) |=> !avail_reg)
        else $error("failed command left receiver available");

    // No tune issued means no frequency reported
    a_no_tune_no_mhz: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !res.tune_request) |-> (res.tune_mhz == 13'd0))
        else $error("tune frequency reported without a tune");

    // A successful select starts with stale signal and a set time stamp
    a_select_resets_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.cmd == CMD_SELECT) && res.ok) |=> (!fresh_reg && seen_reg))
        else $error("select did not reset freshness");

endmodule

### hdl/vrcs_out_stage.sv
// Result register of the channel scan core.
// Holds one result transaction until the receiver takes it; uses vrcs_pkg.
module vrcs_out_stage
    import vrcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  result_t res_in,
    output logic    down_ready,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t res_out
);

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    // Room when empty or when the held result leaves this cycle
    assign down_ready = !vld_reg || !out_stall;
    assign out_valid  = vld_reg;
    assign res_out    = res_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (fire)
            vld_next = 1'b1;
        else if (!out_stall)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_in;
    end

endmodule

### verif/channel_scan_checker.sv
// Checker for the video receiver channel scan core: follows the configuration,
// input and output channels, predicts each result and compares it.
// Depends on vrcs_pkg for the command codes, result struct and frequency table.
module channel_scan_checker
    import vrcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [2:0]         band,
    input  logic [2:0]         channel,
    input  logic [47:0]        now_us,
    input  logic               tune_ok,
    input  logic               has_sample,
    input  logic signed [15:0] rssi,
    input  logic               video_present,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               ok,
    input  logic               tune_request,
    input  logic [12:0]        tune_mhz,
    input  logic               available,
    input  logic               scanning,
    input  logic               sample_fresh,
    input  logic               video_ok,
    input  logic [2:0]         cur_band,
    input  logic [2:0]         cur_channel,
    input  logic [12:0]        cur_mhz,
    input  logic signed [15:0] last_rssi,
    input  logic [6:0]         strength_pct,
    output int                 mismatch_count,
    output int                 results_due
);

    localparam int BANDS = 6;
    localparam int CHANS = 8;

    // Predicted receiver state
    logic [15:0]        dwell_ms;
    int unsigned        scan_idx;
    int unsigned        best_idx;
    int                 best_rssi;
    logic [47:0]        step_deadline;
    logic [47:0]        sample_stamp;
    bit                 stamp_valid;
    bit                 avail_f, scan_f, fresh_f, video_f;
    logic [2:0]         tuned_b, tuned_c;
    logic [12:0]        tuned_f;
    logic signed [15:0] held_rssi;
    logic [6:0]         held_pct;

    // Tune issued by the transaction being predicted
    bit                 tune_issued;
    logic [12:0]        tune_freq;

    result_t            status_queue [$];
    int                 errs;

    // Plain select of one band/channel; returns whether it succeeded
    function automatic bit select_point(input logic [2:0] b, input logic [2:0] c,
                                        input logic [47:0] t, input bit accept);
        logic [12:0] f;
        f = (b < BANDS && c < CHANS) ? FREQ_ROM[b][c] : 13'd0;
        if (f == 13'd0) begin
            avail_f = 1'b0;
            return 1'b0;
        end
        tune_issued = 1'b1;
        tune_freq   = f;
        if (!accept) begin
            avail_f = 1'b0;
            return 1'b0;
        end
        tuned_b      = b;
        tuned_c      = c;
        tuned_f      = f;
        avail_f      = 1'b1;
        scan_f       = 1'b0;
        fresh_f      = 1'b0;
        sample_stamp = t;
        stamp_valid  = 1'b1;
        return 1'b1;
    endfunction

    // Tune the current scan slot, or settle on the best one past the end
    function automatic bit tune_scan_slot(input logic [47:0] t, input bit accept);
        logic [12:0] f;
        logic [15:0] held_dwell;
        if (scan_idx >= BANDS * CHANS) begin
            scan_f = 1'b0;
            return select_point(3'(best_idx / CHANS), 3'(best_idx % CHANS), t, accept);
        end
        f           = FREQ_ROM[scan_idx / CHANS][scan_idx % CHANS];
        tune_issued = 1'b1;
        tune_freq   = f;
        if (!accept) begin
            avail_f = 1'b0;
            scan_f  = 1'b0;
            return 1'b0;
        end
        tuned_b       = 3'(scan_idx / CHANS);
        tuned_c       = 3'(scan_idx % CHANS);
        tuned_f       = f;
        avail_f       = 1'b1;
        fresh_f       = 1'b0;
        held_dwell    = (dwell_ms < MIN_DWELL_MS) ? MIN_DWELL_MS : dwell_ms;
        step_deadline = t + 48'(held_dwell) * 48'd1000;
        return 1'b1;
    endfunction

    // Apply one command transaction and return the status it should produce
    function automatic result_t predict_status(input cmd_t op, input logic [2:0] b,
                                               input logic [2:0] c, input logic [47:0] t,
                                               input bit accept, input bit sv,
                                               input logic signed [15:0] lvl, input bit vid);
        result_t r;
        bit      done;
        int      pct;
        done        = 1'b1;
        tune_issued = 1'b0;
        tune_freq   = 13'd0;
        case (op)
            CMD_SELECT: done = select_point(b, c, t, accept);
            CMD_SCAN:
            begin
                scan_idx      = 0;
                best_idx      = 0;
                best_rssi     = -32768;
                scan_f        = 1'b1;
                step_deadline = t;
                done          = tune_scan_slot(t, accept);
            end
            CMD_CANCEL: scan_f = 1'b0;
            default:
            begin
                // ticks only act on a tuned receiver
                if (avail_f) begin
                    if (sv) begin
                        pct = (int'(lvl) + 100) * 100 / 80;
                        if (pct < 0)
                            pct = 0;
                        else if (pct > 100)
                            pct = 100;
                        held_rssi    = lvl;
                        held_pct     = 7'(pct);
                        video_f      = vid;
                        fresh_f      = 1'b1;
                        sample_stamp = t;
                        stamp_valid  = 1'b1;
                        if (scan_f && int'(lvl) > best_rssi) begin
                            best_rssi = int'(lvl);
                            best_idx  = scan_idx & 63;
                        end
                    end
                    else if (!stamp_valid || (t - sample_stamp) > 48'd1000000) begin
                        fresh_f = 1'b0;
                        video_f = 1'b0;
                    end
                    // dwell deadline is a plain compare, no wrap handling
                    if (scan_f && t >= step_deadline) begin
                        scan_idx = scan_idx + 1;
                        void'(tune_scan_slot(t, accept));
                        scan_idx = scan_idx & 63;
                    end
                end
            end
        endcase
        r.ok           = done;
        r.tune_request = tune_issued;
        r.tune_mhz     = tune_freq;
        r.available    = avail_f;
        r.scanning     = scan_f;
        r.sample_fresh = fresh_f;
        r.video_ok     = video_f;
        r.cur_band     = tuned_b;
        r.cur_channel  = tuned_c;
        r.cur_mhz      = tuned_f;
        r.last_rssi    = held_rssi;
        r.strength_pct = held_pct;
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
        if (got_v !== want_v) begin
            errs++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    // Track configuration, score results, queue predictions
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            dwell_ms      = MIN_DWELL_MS;
            scan_idx      = 0;
            best_idx      = 0;
            best_rssi     = -32768;
            step_deadline = '0;
            sample_stamp  = '0;
            stamp_valid   = 1'b0;
            avail_f       = 1'b0;
            scan_f        = 1'b0;
            fresh_f       = 1'b0;
            video_f       = 1'b0;
            tuned_b       = '0;
            tuned_c       = '0;
            tuned_f       = '0;
            held_rssi     = '0;
            held_pct      = '0;
            errs          = 0;
            status_queue.delete();
            mismatch_count <= 0;
            results_due    <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                dwell_ms = cfg_data;

            if (out_valid && !out_stall) begin
                if (status_queue.size() == 0) begin
                    errs++;
                    $display("%0t: result transaction with no command outstanding", $time);
                end
                else begin
                    want = status_queue.pop_front();
                    check_field("ok", want.ok, ok);
                    check_field("tune_request", want.tune_request, tune_request);
                    check_field("tune_mhz", want.tune_mhz, tune_mhz);
                    check_field("available", want.available, available);
                    check_field("scanning", want.scanning, scanning);
                    check_field("sample_fresh", want.sample_fresh, sample_fresh);
                    check_field("video_ok", want.video_ok, video_ok);
                    check_field("cur_band", want.cur_band, cur_band);
                    check_field("cur_channel", want.cur_channel, cur_channel);
                    check_field("cur_mhz", want.cur_mhz, cur_mhz);
                    check_field("last_rssi", want.last_rssi, last_rssi);
                    check_field("strength_pct", want.strength_pct, strength_pct);
                end
            end

            if (in_valid && !in_stall) begin
                want = predict_status(cmd_t'(cmd), band, channel, now_us, tune_ok,
                                      has_sample, rssi, video_present);
                status_queue = {status_queue, want};
            end

            mismatch_count <= errs;
            results_due    <= status_queue.size();
        end
    end

endmodule

### verif/testbench.sv
// Top of the channel scan core testbench: clock, reset, command stimulus,
// output back-pressure and the final verdict.
// Depends on vrcs_pkg, video_receiver_channel_scan_core and channel_scan_checker.
module testbench
    import vrcs_pkg::*;
();

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         cmd;
    logic [2:0]         band;
    logic [2:0]         channel;
    logic [47:0]        now_us;
    logic               tune_ok;
    logic               has_sample;
    logic signed [15:0] rssi;
    logic               video_present;
    logic               out_valid;
    logic               out_stall;
    logic               ok;
    logic               tune_request;
    logic [12:0]        tune_mhz;
    logic               available;
    logic               scanning;
    logic               sample_fresh;
    logic               video_ok;
    logic [2:0]         cur_band;
    logic [2:0]         cur_channel;
    logic [12:0]        cur_mhz;
    logic signed [15:0] last_rssi;
    logic [6:0]         strength_pct;
    int                 mismatch_count;
    int                 results_due;

    logic [47:0]        clock_us;   // receiver time carried by the next command
    int unsigned        dwell_us;   // effective dwell in us
    int                 sent;
    bit                 calm;       // no idling on either side while set

    video_receiver_channel_scan_core DUT (.*);
    channel_scan_checker u_check (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] rand_level();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 110)) - 115);
    endfunction

    // Time between ticks, weighted towards the 1 s freshness boundary
    function automatic int unsigned idle_span();
        case ($urandom_range(0, 4))
            0, 1:    return $urandom_range(0, 50000);
            2:       return $urandom_range(999_000, 1_001_000);
            3:       return 1_000_000 + $urandom_range(0, 1);
            default: return $urandom_range(0, 5_000_000);
        endcase
    endfunction

    // Present one command transaction and hold it until it is taken
    task automatic issue(input cmd_t op, input logic [2:0] b, input logic [2:0] c,
                         input bit accept, input bit sv, input logic signed [15:0] lvl,
                         input bit vid);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        band          <= b;
        channel       <= c;
        now_us        <= clock_us;
        tune_ok       <= accept;
        has_sample    <= sv;
        rssi          <= lvl;
        video_present <= vid;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic tick(input int unsigned adv, input bit accept, input bit sv,
                        input logic signed [15:0] lvl, input bit vid);
        clock_us = clock_us + 48'(adv);
        issue(CMD_TICK, 3'($urandom), 3'($urandom), accept, sv, lvl, vid);
    endtask

    // Stop sending and wait until every result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_dwell(input logic [15:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        dwell_us = ((v < MIN_DWELL_MS) ? 32'(MIN_DWELL_MS) : 32'(v)) * 1000;
    endtask

    // Full scan: start, then enough dwell-length ticks to walk every channel, unless broken off early
    task automatic run_scan_pass();
        int steps;
        issue(CMD_SCAN, 3'($urandom), 3'($urandom), $urandom_range(0, 15) != 0,
              1'($urandom), rand_level(), 1'($urandom));
        steps = 0;
        while (steps < 49) begin
            if ($urandom_range(0, 99) < 3) begin
                // break the scan off early
                if ($urandom_range(0, 1) == 0)
                    issue(CMD_CANCEL, 3'($urandom), 3'($urandom), 1'($urandom),
                          1'($urandom), rand_level(), 1'($urandom));
                else
                    issue(CMD_SELECT, 3'($urandom), 3'($urandom), $urandom_range(0, 3) != 0,
                          1'($urandom), rand_level(), 1'($urandom));
                return;
            end
            if ($urandom_range(0, 99) < 15)
                tick($urandom_range(0, dwell_us / 2), 1'b1, $urandom_range(0, 6) != 0,
                     rand_level(), 1'($urandom));
            else begin
                tick(dwell_us + $urandom_range(0, 3000), $urandom_range(0, 199) != 0,
                     $urandom_range(0, 6) != 0, rand_level(), 1'($urandom));
                steps++;
            end
        end
    endtask

    task automatic run_select_burst();
        repeat ($urandom_range(1, 3)) begin
            issue(CMD_SELECT, 3'($urandom), 3'($urandom), $urandom_range(0, 9) != 0,
                  1'($urandom), rand_level(), 1'($urandom));
            repeat ($urandom_range(1, 6))
                tick(idle_span(), 1'($urandom), $urandom_range(0, 3) != 0, rand_level(),
                     1'($urandom));
        end
    endtask

    // Arbitrary commands, with the odd jump of the time base anywhere
    task automatic run_noise();
        repeat ($urandom_range(3, 10)) begin
            if ($urandom_range(0, 9) == 0)
                clock_us = {16'($urandom), $urandom};
            else
                clock_us = clock_us + 48'(idle_span());
            issue(cmd_t'($urandom_range(0, 3)), 3'($urandom), 3'($urandom), 1'($urandom),
                  1'($urandom), 16'($urandom), 1'($urandom));
        end
    endtask

    // Output back-pressure
    initial begin
        int n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Stimulus and verdict
    initial begin
        int unsigned dwell_plan [5];
        int          roll;
        int          target;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        cmd           <= CMD_TICK;
        band          <= '0;
        channel       <= '0;
        now_us        <= '0;
        tune_ok       <= 1'b0;
        has_sample    <= 1'b0;
        rssi          <= '0;
        video_present <= 1'b0;
        clock_us = '0;
        dwell_us = 20_000;
        sent     = 0;
        calm     = 1'b0;
        dwell_plan = '{0, 65535, 19, 21, 0};
        dwell_plan[4] = $urandom_range(22, 300);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // receiver not tuned yet: a tick changes nothing
        tick(0, 1'b1, 1'b1, -16'sd50, 1'b1);
        // scan tuned before any sample: tick without sample clears freshness
        issue(CMD_SCAN, 3'd0, 3'd0, 1'b1, 1'b0, 16'sd0, 1'b0);
        tick(1000, 1'b1, 1'b0, 16'sd0, 1'b0);
        // strength extremes and the clamp edges
        tick(1000, 1'b1, 1'b1, 16'sh7fff, 1'b1);
        tick(1000, 1'b1, 1'b1, 16'sh8000, 1'b0);
        tick(1000, 1'b1, 1'b1, -16'sd99, 1'b1);
        tick(1000, 1'b1, 1'b1, -16'sd20, 1'b1);
        tick(1000, 1'b1, 1'b1, -16'sd21, 1'b0);
        tick(1000, 1'b1, 1'b1, -16'sd100, 1'b0);
        // tuner refuses the next scan step
        tick(20_000, 1'b0, 1'b1, -16'sd60, 1'b1);
        // bands outside the table, refusal, then a good select
        issue(CMD_SELECT, 3'd7, 3'd7, 1'b1, 1'b0, 16'sd0, 1'b0);
        issue(CMD_SELECT, 3'd6, 3'd0, 1'b1, 1'b0, 16'sd0, 1'b0);
        issue(CMD_SELECT, 3'd5, 3'd7, 1'b0, 1'b0, 16'sd0, 1'b0);
        issue(CMD_SELECT, 3'd5, 3'd0, 1'b1, 1'b0, 16'sd0, 1'b0);
        // freshness timeout, exactly at and just past 1 s
        tick(1_000_000, 1'b1, 1'b0, 16'sd0, 1'b0);
        tick(1, 1'b1, 1'b0, 16'sd0, 1'b0);
        // failed select mid-scan leaves the scan stuck until cancelled
        issue(CMD_SCAN, 3'd3, 3'd3, 1'b1, 1'b0, 16'sd0, 1'b0);
        issue(CMD_SELECT, 3'd7, 3'd0, 1'b1, 1'b0, 16'sd0, 1'b0);
        tick(50_000, 1'b1, 1'b1, -16'sd30, 1'b1);
        issue(CMD_CANCEL, 3'd0, 3'd0, 1'b1, 1'b0, 16'sd0, 1'b0);
        issue(CMD_SCAN, 3'd0, 3'd0, 1'b0, 1'b0, 16'sd0, 1'b0);
        // freshness timeout across the time wrap
        clock_us = 48'hFFFF_FFFF_FFFF - 48'd499;
        issue(CMD_SELECT, 3'd0, 3'd7, 1'b1, 1'b0, 16'sd0, 1'b0);
        tick(0, 1'b1, 1'b1, -16'sd40, 1'b1);
        tick(999_999, 1'b1, 1'b0, 16'sd0, 1'b0);
        tick(2, 1'b1, 1'b0, 16'sd0, 1'b0);
        // dwell deadline wraps past zero, so the next tick steps at once
        clock_us = 48'hFFFF_FFFF_FFFF - 48'd5000;
        issue(CMD_SCAN, 3'd2, 3'd4, 1'b1, 1'b0, 16'sd0, 1'b0);
        tick(10, 1'b1, 1'b1, -16'sd70, 1'b0);
        issue(CMD_CANCEL, 3'd0, 3'd0, 1'b1, 1'b0, 16'sd0, 1'b0);

        // random phases, one per dwell setting
        foreach (dwell_plan[i]) begin
            set_dwell(16'(dwell_plan[i]));
            target = sent + 75;
            while (sent < target) begin
                calm = ($urandom_range(0, 4) == 0);
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    run_scan_pass();
                else if (roll < 70)
                    run_select_burst();
                else
                    run_noise();
            end
        end
        calm = 1'b0;

        settle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
